/* hdl/dtn_pkg.sv */
// Shared types, character codes, microcode encoding and tables for the decimal text converter.
package dtn_pkg;

    localparam int FRACTION_BITS_DEF   = 32;
    localparam int MAX_FRACTION_DIGITS = 9;
    localparam int PC_W                = 3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [PC_W-1:0] STEP_IDLE     = 3'd0;
    localparam logic [PC_W-1:0] STEP_TAKE     = 3'd1;
    localparam logic [PC_W-1:0] STEP_DIV_INIT = 3'd2;
    localparam logic [PC_W-1:0] STEP_DIV_STEP = 3'd3;
    localparam logic [PC_W-1:0] STEP_FORM     = 3'd4;
    localparam logic [PC_W-1:0] STEP_EMIT     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_LATCH    = 3'd1,
        OP_TAKE     = 3'd2,
        OP_DIV_INIT = 3'd3,
        OP_DIV_STEP = 3'd4,
        OP_FORM     = 3'd5,
        OP_EMIT     = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_NO_ACCEPT = 3'd1,
        C_NOT_LAST  = 3'd2,
        C_SKIP_DIV  = 3'd3,
        C_DIV_BUSY  = 3'd4,
        C_OUT_FULL  = 3'd5
    } cond_t;

    typedef struct packed {
        logic            in_ready;
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] goto_t;
        logic [PC_W-1:0] goto_f;
    } ucode_t;

    typedef struct packed {
        logic in_ready;
        op_t  op;
    } ctrl_t;

    typedef struct packed {
        logic last_char;
        logic skip_div;
        logic div_busy;
        logic out_free;
    } flags_t;

    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

/* hdl/dtn_sequencer.sv */
// Microcode step counter and control store for the decimal text converter.
module dtn_sequencer
    import dtn_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            cond_hit;

    // control store
    always_comb begin
        case (pc_reg)
            STEP_IDLE:     word = '{1'b1, OP_LATCH,    C_NO_ACCEPT, STEP_IDLE,     STEP_TAKE};
            STEP_TAKE:     word = '{1'b0, OP_TAKE,     C_NOT_LAST,  STEP_IDLE,     STEP_DIV_INIT};
            STEP_DIV_INIT: word = '{1'b0, OP_DIV_INIT, C_SKIP_DIV,  STEP_FORM,     STEP_DIV_STEP};
            STEP_DIV_STEP: word = '{1'b0, OP_DIV_STEP, C_DIV_BUSY,  STEP_DIV_STEP, STEP_FORM};
            STEP_FORM:     word = '{1'b0, OP_FORM,     C_NEVER,     STEP_EMIT,     STEP_EMIT};
            STEP_EMIT:     word = '{1'b0, OP_EMIT,     C_OUT_FULL,  STEP_EMIT,     STEP_IDLE};
            default:       word = '{1'b0, OP_NOP,      C_NEVER,     STEP_IDLE,     STEP_IDLE};
        endcase
    end

    always_comb begin
        case (word.cond)
            C_NEVER:     cond_hit = 1'b0;
            C_NO_ACCEPT: cond_hit = !s_valid;
            C_NOT_LAST:  cond_hit = !flags.last_char;
            C_SKIP_DIV:  cond_hit = flags.skip_div;
            C_DIV_BUSY:  cond_hit = flags.div_busy;
            C_OUT_FULL:  cond_hit = !flags.out_free;
            default:     cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? word.goto_t : word.goto_f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.in_ready = word.in_ready;
    assign ctrl.op       = word.op;

endmodule

/* hdl/dtn_datapath.sv */
// String state, digit accumulators, fraction divider and result register.
module dtn_datapath
    import dtn_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ctrl_t       ctrl,
    output flags_t      flags,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic [1:0]  m_status
);

    localparam int          CW      = $clog2(FRACTION_BITS + 1);
    localparam logic [63:0] LIM_INT = 64'd1 << 31;
    localparam logic [63:0] LIM_FIX = 64'd1 << (31 + FRACTION_BITS);

    logic mode_reg;
    logic [7:0] char_reg, char_next;
    logic last_reg, last_next;
    logic start_reg, start_next;
    logic neg_reg, neg_next;
    logic first_reg, first_next;
    logic frac_reg, frac_next;
    logic stop_reg, stop_next;
    logic bad_reg, bad_next;
    logic sat_reg, sat_next;
    logic [31:0] iacc_reg, iacc_next;
    logic [29:0] facc_reg, facc_next;
    logic [3:0] fcnt_reg, fcnt_next;
    logic [29:0] rem_reg, rem_next;
    logic [29:0] dvs_reg, dvs_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic [63:0] mag_reg, mag_next;
    status_t st_reg, st_next;
    logic out_valid_reg, out_valid_next;
    logic [63:0] out_value_reg, out_value_next;
    status_t out_status_reg, out_status_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] iacc_prod;
    logic [33:0] facc_prod;
    logic [30:0] rem_dbl;
    logic [30:0] rem_sub;
    logic        rem_ge;
    logic [63:0] mag_raw;
    logic [63:0] mag_lim;
    logic        out_free;

    assign is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign digit     = 4'(char_reg - CH_ZERO);
    assign iacc_prod = {1'b0, iacc_reg, 3'b000} + {3'b000, iacc_reg, 1'b0} + 36'(digit);
    assign facc_prod = {1'b0, facc_reg, 3'b000} + {3'b000, facc_reg, 1'b0} + 34'(digit);
    assign rem_dbl   = {rem_reg, 1'b0};
    assign rem_sub   = rem_dbl - {1'b0, dvs_reg};
    assign rem_ge    = rem_dbl >= {1'b0, dvs_reg};
    assign mag_raw   = mode_reg ? 64'({iacc_reg, quo_reg}) : 64'(iacc_reg);
    assign mag_lim   = (mode_reg ? LIM_FIX : LIM_INT) - 64'(!neg_reg);
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        char_next       = char_reg;
        last_next       = last_reg;
        start_next      = start_reg;
        neg_next        = neg_reg;
        first_next      = first_reg;
        frac_next       = frac_reg;
        stop_next       = stop_reg;
        bad_next        = bad_reg;
        sat_next        = sat_reg;
        iacc_next       = iacc_reg;
        facc_next       = facc_reg;
        fcnt_next       = fcnt_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        quo_next        = quo_reg;
        dcnt_next       = dcnt_reg;
        mag_next        = mag_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        case (ctrl.op)
            OP_LATCH: begin
                if (ctrl.in_ready && s_valid) begin
                    char_next = s_char_code;
                    last_next = s_last_char;
                end
            end
            OP_TAKE: begin
                start_next = 1'b0;
                if (start_reg && char_reg == CH_MINUS) begin
                    neg_next = 1'b1;
                end else begin
                    first_next = 1'b0;
                    if (!bad_reg) begin
                        if (!mode_reg) begin
                            if (!stop_reg) begin
                                if (is_digit) begin
                                    if (|iacc_prod[35:32]) begin
                                        iacc_next = '1;
                                        sat_next  = 1'b1;
                                    end else begin
                                        iacc_next = iacc_prod[31:0];
                                    end
                                end else if (char_reg == CH_DOT && !first_reg) begin
                                    stop_next = 1'b1;
                                end else begin
                                    bad_next = 1'b1;
                                end
                            end
                        end else if (char_reg == CH_DOT) begin
                            if (first_reg || frac_reg) begin
                                bad_next = 1'b1;
                            end else begin
                                frac_next = 1'b1;
                            end
                        end else if (!is_digit) begin
                            bad_next = 1'b1;
                        end else if (frac_reg) begin
                            if (fcnt_reg < 4'(MAX_FRACTION_DIGITS)) begin
                                facc_next = facc_prod[29:0];
                                fcnt_next = fcnt_reg + 4'd1;
                            end
                        end else if (|iacc_prod[35:32]) begin
                            iacc_next = '1;
                            sat_next  = 1'b1;
                        end else begin
                            iacc_next = iacc_prod[31:0];
                        end
                    end
                end
            end
            OP_DIV_INIT: begin
                rem_next  = facc_reg;
                dvs_next  = pow10(fcnt_reg);
                quo_next  = '0;
                dcnt_next = CW'(FRACTION_BITS);
            end
            OP_DIV_STEP: begin
                rem_next  = rem_ge ? rem_sub[29:0] : rem_dbl[29:0];
                quo_next  = {quo_reg[FRACTION_BITS-2:0], rem_ge};
                dcnt_next = dcnt_reg - CW'(1);
            end
            OP_FORM: begin
                if (bad_reg) begin
                    mag_next = '0;
                    st_next  = ST_BAD;
                end else begin
                    mag_next = (mag_raw > mag_lim) ? mag_lim : mag_raw;
                    st_next  = (mag_raw > mag_lim || sat_reg) ? ST_SAT : ST_OK;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = neg_reg ? (64'd0 - mag_reg) : mag_reg;
                    out_status_next = st_reg;
                    start_next      = 1'b1;
                    neg_next        = 1'b0;
                    first_next      = 1'b1;
                    frac_next       = 1'b0;
                    stop_next       = 1'b0;
                    bad_next        = 1'b0;
                    sat_next        = 1'b0;
                    iacc_next       = '0;
                    facc_next       = '0;
                    fcnt_next       = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            start_reg     <= 1'b1;
            neg_reg       <= 1'b0;
            first_reg     <= 1'b1;
            frac_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            iacc_reg      <= '0;
            facc_reg      <= '0;
            fcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            start_reg     <= start_next;
            neg_reg       <= neg_next;
            first_reg     <= first_next;
            frac_reg      <= frac_next;
            stop_reg      <= stop_next;
            bad_reg       <= bad_next;
            sat_reg       <= sat_next;
            iacc_reg      <= iacc_next;
            facc_reg      <= facc_next;
            fcnt_reg      <= fcnt_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg       <= char_next;
        last_reg       <= last_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        quo_reg        <= quo_next;
        mag_reg        <= mag_next;
        st_reg         <= st_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign flags.last_char = last_reg;
    assign flags.skip_div  = !mode_reg || bad_reg;
    assign flags.div_busy  = dcnt_reg != CW'(1);
    assign flags.out_free  = out_free;

    assign m_valid  = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;

endmodule

/* hdl/decimal_text_to_number_top.sv */
// Top level of the decimal text to integer / fixed-point converter.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_char_code s_last_char      | in
//  result  | m_valid m_ready m_value m_status             | out
//  config  | cfg_wr_en cfg_wr_data (conversion mode)      | in
//
// Idle step takes a character request; the take step then updates the string state.
// On the last character, integer mode goes on to divider setup, form and clamp, and emit;
// fixed mode also runs the one-bit-per-cycle restoring divider between setup and form.
// Synchronous active-low reset; the block is ready for a request right after it.
// A stalled result holds in the output register; the sequencer waits in its emit step.
module decimal_text_to_number_top
    import dtn_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic [1:0]  m_status
);

    ctrl_t  ctrl;
    flags_t flags;

    dtn_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    dtn_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .flags       (flags),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status)
    );

    assign s_ready = ctrl.in_ready;

endmodule

/* hdl/dtn_checker.sv */
// Port-level checks for the decimal text converter, bound to the top level.
module dtn_checker
    import dtn_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_value,
    input logic [1:0]  m_status
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_BAD || m_status == ST_SAT))
        else $error("unknown status code");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_BAD |-> m_value == 64'd0)
        else $error("bad string gave nonzero value");

    a_char_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in work");

endmodule

bind decimal_text_to_number_top dtn_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_value  (m_value),
    .m_status (m_status)
);

/* tb/sv/decimal_text_checker.sv */
// Checker for the decimal text converter: tracks requests, predicts each number, compares results.
module decimal_text_checker
    import dtn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_value,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_W      = FRACTION_BITS_DEF;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
    } number_t;

    number_t     expected_numbers[$];

    logic        fixed_mode;
    logic        first_char;
    logic        minus_seen;
    logic        no_digit_yet;
    logic        in_frac;
    logic        int_halted;
    logic        bad_seen;
    logic        clipped;
    logic [31:0] int_acc;
    logic [29:0] frac_acc;
    logic [3:0]  frac_cnt;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    function automatic void clear_string();
        first_char   = 1'b1;
        minus_seen   = 1'b0;
        no_digit_yet = 1'b1;
        in_frac      = 1'b0;
        int_halted   = 1'b0;
        bad_seen     = 1'b0;
        clipped      = 1'b0;
        int_acc      = '0;
        frac_acc     = '0;
        frac_cnt     = '0;
    endfunction

    // integer part saturates at all ones instead of wrapping
    function automatic void add_int_digit(input logic [3:0] d);
        logic [35:0] nx;
        nx = {4'd0, int_acc} * 36'd10 + 36'(d);
        if (nx > 36'hFFFF_FFFF) begin
            int_acc = '1;
            clipped = 1'b1;
        end else begin
            int_acc = nx[31:0];
        end
    endfunction

    function automatic void accept_char(input logic [7:0] c, input logic last);
        logic        is_dig;
        logic [3:0]  d;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] div;
        number_t     num;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d = 4'(c - CH_ZERO);
        if (first_char && c == CH_MINUS) begin
            minus_seen = 1'b1;
        end else if (!bad_seen && !(!fixed_mode && int_halted)) begin
            if (!fixed_mode) begin
                if (is_dig) add_int_digit(d);
                else if (c == CH_DOT && !no_digit_yet) int_halted = 1'b1;
                else bad_seen = 1'b1;
            end else if (c == CH_DOT) begin
                if (no_digit_yet || in_frac) bad_seen = 1'b1;
                else in_frac = 1'b1;
            end else if (!is_dig) begin
                bad_seen = 1'b1;
            end else if (in_frac) begin
                if (frac_cnt < MAX_FRACTION_DIGITS) begin
                    frac_acc = frac_acc * 30'd10 + 30'(d);
                    frac_cnt++;
                end
            end else begin
                add_int_digit(d);
            end
            no_digit_yet = 1'b0;
        end
        first_char = 1'b0;
        if (!last) return;

        if (bad_seen) begin
            num.value  = '0;
            num.status = ST_BAD;
        end else begin
            mag = 64'(int_acc) << (fixed_mode ? FRAC_W : 0);
            if (fixed_mode) begin
                div = 64'd1;
                repeat (frac_cnt) div = div * 64'd10;
                mag = mag + ((64'(frac_acc) << FRAC_W) / div);
            end
            lim = (64'd1 << (31 + (fixed_mode ? FRAC_W : 0))) - (minus_seen ? 64'd0 : 64'd1);
            num.status = (clipped || mag > lim) ? ST_SAT : ST_OK;
            if (mag > lim) mag = lim;
            num.value = minus_seen ? -mag : mag;
        end
        expected_numbers.push_back(num);
        clear_string();
    endfunction

    always @(posedge aclk) begin
        number_t want;
        if (!aresetn) begin
            fixed_mode = 1'b0;
            clear_string();
            expected_numbers.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch($sformatf("result %h/%0d with no request pending",
                                              m_value, m_status));
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_value !== want.value)
                        report_mismatch($sformatf("value %h, want %h", m_value, want.value));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                end
            end
            if (cfg_wr_en) fixed_mode = cfg_wr_data;
            if (s_valid && s_ready) accept_char(s_char_code, s_last_char);
        end
        pending_count = expected_numbers.size();
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top: clock, reset, mode writes, character requests, result back-pressure, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtn_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_STALL  = 400;
    localparam int PHASE_ITEMS = 360;
    localparam int SETTLE      = 60;

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic            cfg_wr_data = 1'b0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    logic [7:0]      s_char_code = 8'd0;
    logic            s_last_char = 1'b0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    logic [63:0]     m_value;
    logic [1:0]      m_status;
    int              fail_count;
    int              pending_count;
    int              cycle_count = 0;
    int              rx_wait     = 0;
    int              rx_free     = 0;
    int              stall_left  = LONG_STALL;
    bit              stall_go    = 1'b0;
    bit              steady      = 1'b0;
    int              phase_chars;
    logic [7:0]      word[$];
    longint unsigned boundary_values[6] = '{64'd0, 64'd2147483647, 64'd2147483648,
                                            64'd2147483649, 64'd4294967295, 64'd4294967296};

    decimal_text_to_number_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status)
    );

    decimal_text_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_last_char   (s_last_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_status      (m_status),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: one long hold-off once requested, otherwise random stalls and free runs
    always @(negedge aclk) begin
        int r;
        if (stall_go && stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (rx_wait > 0) begin
            m_ready = 1'b0;
            rx_wait--;
        end else begin
            m_ready = 1'b1;
            if (rx_free > 0) begin
                rx_free--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) rx_free = $urandom_range(50, 150);
                else if (r < 35) rx_wait = pick_gap();
            end
        end
    end

    // entered and left at a falling edge; valid stays up until the next call or settle
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_char_code = c;
        s_last_char = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_word(input bit close);
        for (int i = 0; i < word.size(); i++) send_char(word[i], close && i == word.size() - 1);
    endtask

    task automatic send_text(input string t, input bit close);
        word.delete();
        for (int i = 0; i < t.len(); i++) word.push_back(t[i]);
        send_word(close);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        wait (pending_count == 0);
        @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_mode(input logic m);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // mostly well-formed numbers with random content, some noise and corrupted strings
    task automatic build_word();
        int              kind;
        int              n;
        int              pick;
        int              pos;
        bit              nines;
        longint unsigned num;
        logic [7:0]      digits[$];
        logic [7:0]      extra;
        word.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) word.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 1) == 1) word.push_back(CH_MINUS);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            n = (pick < 4) ? $urandom_range(1, 4) : $urandom_range(0, 12);
            repeat (n) word.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
            num = boundary_values[$urandom_range(0, 5)];
            n = $urandom_range(0, 2);
            repeat (n) word.push_back(CH_ZERO);
            do begin
                digits.push_front(8'(CH_ZERO + num % 10));
                num = num / 10;
            end while (num != 0);
            foreach (digits[i]) word.push_back(digits[i]);
        end
        if ($urandom_range(0, 2) != 0) begin
            word.push_back(CH_DOT);
            n = $urandom_range(0, 12);
            nines = $urandom_range(0, 4) == 0;
            repeat (n) word.push_back(nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if (word.size() == 0) word.push_back(CH_ZERO);
        if (kind >= 85) begin
            pick = $urandom_range(0, 2);
            extra = (pick == 0) ? CH_DOT : (pick == 1) ? CH_MINUS : 8'($urandom_range(0, 255));
            pos = $urandom_range(0, word.size());
            word.insert(pos, extra);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_mode(1'b0);
        send_text("-", 1'b1);
        send_text(".", 1'b1);
        send_text("7.x", 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("5-", 1'b1);
        send_char(8'h00, 1'b1);
        settle();

        set_mode(1'b1);
        send_text("-1.5", 1'b1);
        send_text("1..2", 1'b1);
        send_text(".5", 1'b1);
        send_text("9", 1'b1);
        send_text("12", 1'b0);
        settle();

        // string started in fixed mode finishes in integer mode
        set_mode(1'b0);
        send_text(".5", 1'b1);
        settle();

        for (int p = 0; p < 4; p++) begin
            set_mode(p % 2 == 0);
            if (p == 0) stall_go = 1'b1;
            phase_chars = 0;
            while (phase_chars < PHASE_ITEMS) begin
                build_word();
                steady = $urandom_range(0, 4) == 0;
                send_word(1'b1);
                phase_chars += word.size();
            end
            steady = 1'b0;
            settle();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
